### src/sorted_list_table_top_assert.svh
// Assertion macros shared by the sorted list table checker.
`ifndef SORTED_LIST_TABLE_TOP_ASSERT_SVH
`define SORTED_LIST_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/slt_pkg.sv
// Types and constants of the sorted list table.
package slt_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int CMD_W        = 2;
	localparam int OCC_W        = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_code_t;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic             dropped;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DOWN,
		S_PUT,
		S_FIND,
		S_SHIFT
	} ctl_state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_TOP,
		IDX_ZERO,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_UP_ENTRY,
		WR_UP_VALUE,
		WR_DN_ENTRY,
		WR_ZERO_VALUE
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic    load_value;
		idx_op_t idx_op;
		wr_op_t  wr_op;
		cnt_op_t cnt_op;
		logic    res_valid;
		logic    res_found;
		logic    res_dropped;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic greater;
		logic equal;
		logic idx_zero;
		logic idx_last;
	} dp_stat_t;

endpackage

### src/sorted_list_table_top.sv
// Top level of the sorted list table: controller and datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------
//   request  | start, busy        | command, value
//   result   | done (one cycle)   | found, dropped, occupancy
//
// A rejected insert, an unused command, or a delete or search on an empty
// table is answered straight from the idle state. Otherwise insert scans down
// past the entries above the value; search scans up from entry zero, and delete
// also moves each later entry down by one place.
// done follows the last cycle with busy already low; the receiver cannot stall.
// Reset clears the count, scan index, done flag and state; the entry RAM needs no clearing.
module sorted_list_table_top #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  slt_pkg::in_item_t  request,
	output logic               busy,
	output logic               done,
	output slt_pkg::out_item_t result
);
	import slt_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	slt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(request.command),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy)
	);

	slt_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.request(request),
		.stat   (dp_stat),
		.done   (done),
		.result (result)
	);

endmodule

### src/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/slt_datapath.sv
// Datapath of the sorted list table: entry RAM, scan index, count, result register.
module slt_datapath #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slt_pkg::dp_cmd_t   cmd,
	input  slt_pkg::in_item_t  request,
	output slt_pkg::dp_stat_t  stat,
	output logic               done,
	output slt_pkg::out_item_t result
);
	import slt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          idx_d;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic signed [VALUE_W-1:0] value_q;
	logic                      done_q;
	out_item_t                 result_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [VALUE_W-1:0] wdata;
	logic [VALUE_W-1:0] rdata;

	always_comb begin
		case (cmd.idx_op)
			IDX_TOP:  idx_d = IDX_W'(count_q - 1'b1);
			IDX_ZERO: idx_d = '0;
			IDX_DEC:  idx_d = idx_q - 1'b1;
			IDX_INC:  idx_d = idx_q + 1'b1;
			default:  idx_d = idx_q;
		endcase
	end

	always_comb begin
		case (cmd.cnt_op)
			CNT_INC: count_d = count_q + 1'b1;
			CNT_DEC: count_d = count_q - 1'b1;
			default: count_d = count_q;
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = idx_q + 1'b1;
		wdata = rdata;
		case (cmd.wr_op)
			WR_UP_ENTRY: begin
				waddr = idx_q + 1'b1;
				wdata = rdata;
			end
			WR_UP_VALUE: begin
				waddr = idx_q + 1'b1;
				wdata = value_q;
			end
			WR_DN_ENTRY: begin
				waddr = idx_q - 1'b1;
				wdata = rdata;
			end
			WR_ZERO_VALUE: begin
				waddr = '0;
				wdata = value_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	slt_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_d),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			idx_q   <= idx_d;
			count_q <= count_d;
			done_q  <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			value_q <= request.value;
		end
		if (cmd.res_valid) begin
			result_q.found     <= cmd.res_found;
			result_q.dropped   <= cmd.res_dropped;
			result_q.occupancy <= OCC_W'(count_d);
		end
	end

	assign stat.full     = (count_q == CNT_W'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.greater  = ($signed(rdata) > value_q);
	assign stat.equal    = ($signed(rdata) == value_q);
	assign stat.idx_zero = (idx_q == '0);
	assign stat.idx_last = ((CNT_W'(idx_q) + 1'b1) == count_q);

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/slt_ctrl.sv
// Controller of the sorted list table: sequences scans and shifts over the entry RAM.
module slt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [slt_pkg::CMD_W-1:0]  command,
	input  slt_pkg::dp_stat_t          stat,
	output slt_pkg::dp_cmd_t           cmd,
	output logic                       busy
);
	import slt_pkg::*;

	ctl_state_t       state_q;
	ctl_state_t       state_d;
	logic [CMD_W-1:0] op_q;
	logic             accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_INSERT) begin
						if (stat.full) begin
							state_d = S_IDLE;
						end else if (stat.empty) begin
							state_d = S_PUT;
						end else begin
							state_d = S_DOWN;
						end
					end else if ((command == CMD_DELETE || command == CMD_SEARCH)
						&& !stat.empty) begin
						state_d = S_FIND;
					end
				end
			end
			S_DOWN: begin
				if (stat.greater) begin
					state_d = stat.idx_zero ? S_PUT : S_DOWN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PUT: begin
				state_d = S_IDLE;
			end
			S_FIND: begin
				if (stat.equal) begin
					if (op_q == CMD_SEARCH || stat.idx_last) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (stat.greater || stat.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (stat.idx_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.idx_op      = IDX_HOLD;
		cmd.wr_op       = WR_NONE;
		cmd.cnt_op      = CNT_HOLD;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_value = 1'b1;
					if (command == CMD_INSERT) begin
						if (stat.full) begin
							cmd.res_valid   = 1'b1;
							cmd.res_dropped = 1'b1;
						end else if (!stat.empty) begin
							cmd.idx_op = IDX_TOP;
						end
					end else if ((command == CMD_DELETE || command == CMD_SEARCH)
						&& !stat.empty) begin
						cmd.idx_op = IDX_ZERO;
					end else begin
						cmd.res_valid = 1'b1;
					end
				end
			end
			S_DOWN: begin
				if (stat.greater) begin
					cmd.wr_op = WR_UP_ENTRY;
					if (!stat.idx_zero) begin
						cmd.idx_op = IDX_DEC;
					end
				end else begin
					cmd.wr_op     = WR_UP_VALUE;
					cmd.cnt_op    = CNT_INC;
					cmd.res_valid = 1'b1;
				end
			end
			S_PUT: begin
				cmd.wr_op     = WR_ZERO_VALUE;
				cmd.cnt_op    = CNT_INC;
				cmd.res_valid = 1'b1;
			end
			S_FIND: begin
				if (stat.equal) begin
					if (op_q == CMD_SEARCH) begin
						cmd.res_valid = 1'b1;
						cmd.res_found = 1'b1;
					end else if (stat.idx_last) begin
						cmd.cnt_op    = CNT_DEC;
						cmd.res_valid = 1'b1;
						cmd.res_found = 1'b1;
					end else begin
						cmd.idx_op = IDX_INC;
					end
				end else if (stat.greater || stat.idx_last) begin
					cmd.res_valid = 1'b1;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_SHIFT: begin
				cmd.wr_op = WR_DN_ENTRY;
				if (stat.idx_last) begin
					cmd.cnt_op    = CNT_DEC;
					cmd.res_valid = 1'b1;
					cmd.res_found = 1'b1;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			default: begin
				cmd.res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= command;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### src/slt_checker.sv
// Port-level checker of the sorted list table and its bind.
`include "sorted_list_table_top_assert.svh"

module slt_checker #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input slt_pkg::in_item_t  request,
	input logic               busy,
	input logic               done,
	input slt_pkg::out_item_t result
);
	import slt_pkg::*;

	`SLT_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	`SLT_ASSERT_NOW(a_done_cause, done, $past(busy) || $past(start), "result without an item")
	`SLT_ASSERT_NOW(a_flags_excl, done, !(result.found && result.dropped), "found and dropped both set")
	`SLT_ASSERT_NOW(a_drop_full, done && result.dropped, result.occupancy == OCC_W'(CAPACITY), "drop while not full")
	`SLT_ASSERT_NEXT(a_accept_result, start && !busy && request.command == CMD_INSERT && done && result.dropped, done || busy, "insert accepted with no progress")

endmodule

bind sorted_list_table_top slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

### sim/tb_sorted_list_table_top.sv
// Self-checking testbench for sorted_list_table_top: shadow table, directed and random items.
`timescale 1ns / 1ps

module tb_sorted_list_table_top;
	import slt_pkg::*;

	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int TOTAL_ITEMS = 1900;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_item_t request = '0;
	logic busy;
	logic done;
	out_item_t result;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	logic signed [VALUE_W-1:0] table_entries[TABLE_DEPTH];
	int table_count = 0;
	int gap_left = 0;
	bit no_idle = 0;
	int idle_cycles = 0;
	int mismatch_count = 0;

	sorted_list_table_top #(
		.CAPACITY(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_item_t apply_table_op(in_item_t item);
		out_item_t res;
		logic signed [VALUE_W-1:0] v;
		int pos;
		int k;
		res = '0;
		v = item.value;
		pos = 0;
		case (item.command)
			CMD_INSERT: begin
				if (table_count >= TABLE_DEPTH) begin
					res.dropped = 1'b1;
				end else begin
					while (pos < table_count && table_entries[pos] <= v)
						pos++;
					for (k = table_count; k > pos; k--)
						table_entries[k] = table_entries[k-1];
					table_entries[pos] = v;
					table_count++;
				end
			end
			CMD_DELETE, CMD_SEARCH: begin
				while (pos < table_count && table_entries[pos] != v)
					pos++;
				if (pos < table_count) begin
					res.found = 1'b1;
					if (item.command == CMD_DELETE) begin
						for (k = pos; k + 1 < table_count; k++)
							table_entries[k] = table_entries[k+1];
						table_count--;
					end
				end
			end
			default: ;
		endcase
		res.occupancy = table_count[OCC_W-1:0];
		return res;
	endfunction

	// present, hold or idle the request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(apply_table_op(request));
			if (!start || !busy) begin
				if (gap_left != 0 || pending_items.size() == 0) begin
					start <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					if ($urandom_range(0, 99) < 3)
						no_idle = !no_idle;
					start <= 1'b1;
					request <= pending_items.pop_front();
					gap_left <= no_idle ? 0 : $urandom_range(0, 6);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding: %p", result);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					mismatch_count++;
				end
				if (result.dropped !== want.dropped) begin
					$error("dropped: expected %0d, got %0d", want.dropped, result.dropped);
					mismatch_count++;
				end
				if (result.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						result.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_sorted_list_table_top failed");
		$finish;
	end

	task automatic queue_item(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
		in_item_t item;
		item.command = cmd;
		item.value = v;
		pending_items.push_back(item);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case ($urandom_range(0, 7))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return -2;
				3: return -1;
				4: return 0;
				5: return 1;
				6: return 2;
				default: return 3;
			endcase
		end
		if (r < 70)
			return $urandom_range(0, 1) ? VALUE_MIN + 1 : VALUE_MAX - 1;
		return $urandom;
	endfunction

	initial begin
		int counted;
		int r;
		int mode;
		logic [CMD_W-1:0] cmd;

		queue_item(CMD_SEARCH, 0);
		queue_item(CMD_DELETE, 0);
		queue_item(CMD_UNUSED, -1);
		queue_item(CMD_INSERT, VALUE_MAX);
		queue_item(CMD_INSERT, VALUE_MIN);
		queue_item(CMD_INSERT, 0);
		queue_item(CMD_INSERT, 0);
		queue_item(CMD_SEARCH, VALUE_MIN);
		queue_item(CMD_DELETE, 0);
		queue_item(CMD_DELETE, 7);
		queue_item(CMD_SEARCH, 0);
		for (int k = 0; k < TABLE_DEPTH - 3; k++)
			queue_item(CMD_INSERT, (k % 2) ? -100 * k : 100 * k);
		queue_item(CMD_INSERT, VALUE_MIN);
		queue_item(CMD_SEARCH, VALUE_MAX);
		queue_item(CMD_DELETE, VALUE_MAX);
		counted = pending_items.size() - 1;

		// alternate fill-heavy, drain-heavy and mixed stretches
		while (counted < TOTAL_ITEMS) begin
			mode = (counted / 48) % 3;
			r = $urandom_range(0, 99);
			if (r < 3) begin
				cmd = CMD_UNUSED;
			end else begin
				r = $urandom_range(0, 99);
				case (mode)
					0: cmd = (r < 65) ? CMD_INSERT : (r < 85) ? CMD_DELETE : CMD_SEARCH;
					1: cmd = (r < 20) ? CMD_INSERT : (r < 85) ? CMD_DELETE : CMD_SEARCH;
					default: cmd = (r < 40) ? CMD_INSERT : (r < 75) ? CMD_DELETE : CMD_SEARCH;
				endcase
				counted++;
			end
			queue_item(cmd, pick_value());
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_sorted_list_table_top passed");
		else
			$display("tb_sorted_list_table_top failed");
		$finish;
	end

endmodule
